// ===== design/cht_pkg.sv =====
// Shared constants, codes and interface types of the chained hash table.
`default_nettype none

package cht_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;
    localparam int CNT_MAX  = (2 ** CNT_W) - 1;

    // Default sizing
    localparam int DEF_NUM_BUCKETS = 64;
    localparam int DEF_NUM_ENTRIES = 256;

    // Reset value of the bucket count register
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    // Key bits consumed per cycle by the modulo unit
    localparam int MOD_STEP = 8;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd3;

    // Modulo unit request and response
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } cht_mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } cht_mod_rsp_t;

endpackage

`default_nettype wire

// ===== design/cht_mod_unit.sv =====
// Iterative key modulo bucket count, MOD_STEP key bits per cycle.
`default_nettype none

module cht_mod_unit
    import cht_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cht_mod_req_t req,
    input  wire logic [CNT_W-1:0] divisor,
    output cht_mod_rsp_t      rsp
);

    localparam int CYCLES = (KEY_W + MOD_STEP - 1) / MOD_STEP;
    localparam int PAD_W  = CYCLES * MOD_STEP;
    localparam int CYC_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;
    localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(CYCLES - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CYC_W-1:0] cyc_reg;
    logic [PAD_W-1:0] bits_reg;
    logic [CNT_W-1:0] div_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic [CNT_W:0]   trial;

    // Restoring remainder: shift in one key bit, subtract when it fits
    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < MOD_STEP; i++)
        begin
            trial = {rem_next, bits_reg[PAD_W-1-i]};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[CNT_W-1:0];
        end
    end

    // Sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cyc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cyc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cyc_reg <= cyc_reg + 1'b1;
                if (cyc_reg == CYC_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and remainder datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            bits_reg <= PAD_W'(req.key);
            div_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            bits_reg <= bits_reg << MOD_STEP;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== design/cht_ctrl.sv =====
// Table sequencer: bucket and entry memories, insert linking and chain walk.
`default_nettype none

module cht_ctrl
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                operation,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [VALUE_W-1:0]  value,
    output cht_mod_req_t             mod_req,
    input  wire cht_mod_rsp_t        mod_rsp,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [VALUE_W-1:0]       found_value
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int USED_W = IDX_W + 1;
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [USED_W-1:0] POOL_SIZE = USED_W'(NUM_ENTRIES);
    localparam logic [BKT_W-1:0]  BKT_LAST  = BKT_W'(NUM_BUCKETS - 1);

    typedef struct packed {
        logic             head_valid;
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
    } bkt_row_t;

    typedef struct packed {
        logic               next_valid;
        logic [IDX_W-1:0]   next;
    } nxt_row_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } kv_row_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_BKT,
        S_LINK,
        S_WALK,
        S_DONE
    } state_t;

    // Memories
    bkt_row_t bkt_mem [NUM_BUCKETS];
    kv_row_t  kv_mem  [NUM_ENTRIES];
    nxt_row_t nxt_mem [NUM_ENTRIES];

    bkt_row_t bkt_rd_reg;
    kv_row_t  kv_rd_reg;
    nxt_row_t nxt_rd_reg;

    // Memory port controls
    logic             bkt_rd_en;
    logic [BKT_W-1:0] bkt_rd_addr;
    logic             bkt_wr_en;
    logic [BKT_W-1:0] bkt_wr_addr;
    bkt_row_t         bkt_wr_data;
    logic             ent_rd_en;
    logic [IDX_W-1:0] ent_rd_addr;
    logic             kv_wr_en;
    kv_row_t          kv_wr_data;
    logic             nxt_wr_en;
    logic [IDX_W-1:0] nxt_wr_addr;
    nxt_row_t         nxt_wr_data;

    // Control and item registers
    state_t              state_reg;
    logic [BKT_W-1:0]    clr_cnt_reg;
    logic [USED_W-1:0]   used_reg;
    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [BKT_W-1:0]    bkt_reg;
    logic [IDX_W-1:0]    link_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;

    logic [IDX_W-1:0]       new_idx;
    logic                   pool_full;
    logic                   key_match;
    logic [BKT_W+CNT_W-1:0] rem_ext;
    logic [BKT_W-1:0]       mod_bucket;

    assign new_idx    = used_reg[IDX_W-1:0];
    assign pool_full  = (used_reg == POOL_SIZE);
    assign key_match  = (kv_rd_reg.key == key_reg);
    assign rem_ext    = {{BKT_W{1'b0}}, mod_rsp.rem};
    assign mod_bucket = rem_ext[BKT_W-1:0];

    // Modulo start on every transfer that needs a bucket
    assign mod_req.start = (state_reg == S_IDLE) && in_valid
                           && !((operation == OP_INSERT) && pool_full);
    assign mod_req.key   = key;

    // Memory port decode
    always_comb
    begin
        bkt_rd_en   = 1'b0;
        bkt_rd_addr = mod_bucket;
        bkt_wr_en   = 1'b0;
        bkt_wr_addr = bkt_reg;
        bkt_wr_data = '0;
        ent_rd_en   = 1'b0;
        ent_rd_addr = bkt_rd_reg.head;
        kv_wr_en    = 1'b0;
        kv_wr_data  = {key_reg, val_reg};
        nxt_wr_en   = 1'b0;
        nxt_wr_addr = new_idx;
        nxt_wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                bkt_wr_en   = 1'b1;
                bkt_wr_addr = clr_cnt_reg;
            end
            S_HASH:
            begin
                bkt_rd_en = mod_rsp.done;
            end
            S_BKT:
            begin
                if (op_reg == OP_INSERT)
                begin
                    kv_wr_en  = 1'b1;
                    nxt_wr_en = 1'b1;
                    bkt_wr_en = 1'b1;
                    bkt_wr_data.head_valid = 1'b1;
                    bkt_wr_data.tail       = new_idx;
                    bkt_wr_data.head       = bkt_rd_reg.head_valid ? bkt_rd_reg.head : new_idx;
                end
                else
                begin
                    ent_rd_en = bkt_rd_reg.head_valid;
                end
            end
            S_LINK:
            begin
                // Old tail now points at the new entry
                nxt_wr_en   = 1'b1;
                nxt_wr_addr = link_reg;
                nxt_wr_data = {1'b1, new_idx};
            end
            S_WALK:
            begin
                ent_rd_en   = !key_match && nxt_rd_reg.next_valid;
                ent_rd_addr = nxt_rd_reg.next;
            end
            S_IDLE, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Bucket memory
    always_ff @(posedge clk)
    begin
        if (bkt_wr_en)
        begin
            bkt_mem[bkt_wr_addr] <= bkt_wr_data;
        end
        if (bkt_rd_en)
        begin
            bkt_rd_reg <= bkt_mem[bkt_rd_addr];
        end
    end

    // Entry pool memories
    always_ff @(posedge clk)
    begin
        if (kv_wr_en)
        begin
            kv_mem[new_idx] <= kv_wr_data;
        end
        if (nxt_wr_en)
        begin
            nxt_mem[nxt_wr_addr] <= nxt_wr_data;
        end
        if (ent_rd_en)
        begin
            kv_rd_reg  <= kv_mem[ent_rd_addr];
            nxt_rd_reg <= nxt_mem[ent_rd_addr];
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            used_reg       <= '0;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            val_reg        <= '0;
            bkt_reg        <= '0;
            link_reg       <= '0;
            res_status_reg <= ST_INSERTED;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_INSERTED;
            out_value_reg  <= '0;
        end
        else
        begin
            // Drained result; a refill from S_DONE sets it again
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BKT_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg  <= operation;
                        key_reg <= key;
                        val_reg <= value;
                        if ((operation == OP_INSERT) && pool_full)
                        begin
                            res_status_reg <= ST_FULL;
                            res_value_reg  <= '0;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    if (mod_rsp.done)
                    begin
                        bkt_reg   <= mod_bucket;
                        state_reg <= S_BKT;
                    end
                end
                S_BKT:
                begin
                    res_value_reg <= '0;
                    if (op_reg == OP_INSERT)
                    begin
                        if (bkt_rd_reg.head_valid)
                        begin
                            link_reg  <= bkt_rd_reg.tail;
                            state_reg <= S_LINK;
                        end
                        else
                        begin
                            used_reg       <= used_reg + 1'b1;
                            res_status_reg <= ST_INSERTED;
                            state_reg      <= S_DONE;
                        end
                    end
                    else if (bkt_rd_reg.head_valid)
                    begin
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        res_status_reg <= ST_MISS;
                        state_reg      <= S_DONE;
                    end
                end
                S_LINK:
                begin
                    used_reg       <= used_reg + 1'b1;
                    res_status_reg <= ST_INSERTED;
                    state_reg      <= S_DONE;
                end
                S_WALK:
                begin
                    // First match from the head is the oldest entry
                    if (key_match)
                    begin
                        res_status_reg <= ST_FOUND;
                        res_value_reg  <= kv_rd_reg.value;
                        state_reg      <= S_DONE;
                    end
                    else if (!nxt_rd_reg.next_valid)
                    begin
                        res_status_reg <= ST_MISS;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_value_reg  <= res_value_reg;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_value = out_value_reg;

endmodule

`default_nettype wire

// ===== design/chained_hash_table_top.sv =====
// Top level of the chained hash table: configuration register, modulo unit, sequencer.
`default_nettype none

// Hash table with separate chaining over a bounded entry pool. Keys hash to
// key modulo the bucket count register (0 acts as 1, values above NUM_BUCKETS
// clamp to NUM_BUCKETS). After reset the block clears the bucket heads, one
// bucket per cycle, before in_ready rises; the register may be written during
// that time. One item is in work at a time. The modulo unit resolves 8 key
// bits per cycle, and a lookup reads one chain entry per cycle from the entry
// memory. An insert hashes the key, reads the bucket row and writes the entry,
// then links the old tail to it if the bucket had a chain. A lookup hashes the
// key, reads the bucket row and walks the chain from its head to a match or
// its end. An insert on a full pool goes straight to its result. The result
// sits in an output register, so the next item is accepted while the
// previous result still waits for out_ready.
module chained_hash_table_top
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [CNT_W-1:0]    cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                operation,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [VALUE_W-1:0]       found_value
);

    localparam int CLAMP_INT = (NUM_BUCKETS < CNT_MAX) ? NUM_BUCKETS : CNT_MAX;
    localparam logic [CNT_W-1:0] CNT_CLAMP = CNT_W'(CLAMP_INT);

    logic [CNT_W-1:0] bucket_count_reg;
    logic [CNT_W-1:0] divisor;
    cht_mod_req_t     mod_req;
    cht_mod_rsp_t     mod_rsp;

    // Bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= CNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            bucket_count_reg <= cfg_wr_data;
        end
    end

    // Effective bucket count
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            divisor = CNT_W'(1);
        end
        else if (int'(bucket_count_reg) > NUM_BUCKETS)
        begin
            divisor = CNT_CLAMP;
        end
        else
        begin
            divisor = bucket_count_reg;
        end
    end

    cht_mod_unit u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mod_req),
        .divisor (divisor),
        .rsp     (mod_rsp)
    );

    cht_ctrl #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .mod_req     (mod_req),
        .mod_rsp     (mod_rsp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value)
    );

endmodule

`default_nettype wire

// ===== design/cht_checker.sv =====
// Port-level assertions for the chained hash table, bound to the top level.
`default_nettype none

module cht_checker
    import cht_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [VALUE_W-1:0]  found_value
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_value))
        else $error("result changed while stalled");

    // Only a hit carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FOUND) |-> (found_value == '0))
        else $error("nonzero value on a result that is not a hit");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer accepted while busy");

    // No result appears the cycle right after a transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised immediately after a transfer");

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value)
);

`default_nettype wire
